// ===== src/i2crd_pkg.sv =====
// Shared types and constants for the I2C register-read master.
// Used by i2crd_engine and i2c_register_read_master; no dependencies.
package i2crd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS    = 2'd0;
    localparam logic [1:0] REG_REGISTER_POINTER  = 2'd1;
    localparam logic [1:0] REG_HALF_PERIOD_TICKS = 2'd2;

    // Configuration reset values
    localparam logic [6:0]  DEVICE_ADDRESS_RST    = 7'd72;
    localparam logic [7:0]  REGISTER_POINTER_RST  = 8'd0;
    localparam logic [15:0] HALF_PERIOD_TICKS_RST = 16'd1000;

    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 16;

    // Bus phase, one-hot
    typedef enum logic [14:0] {
        PH_IDLE    = 15'h0001,
        PH_START   = 15'h0002,
        PH_WBIT_LO = 15'h0004,
        PH_WBIT_HI = 15'h0008,
        PH_ACK_LO  = 15'h0010,
        PH_ACK_HI  = 15'h0020,
        PH_RS_LO   = 15'h0040,
        PH_RS_HI   = 15'h0080,
        PH_RBIT_LO = 15'h0100,
        PH_RBIT_HI = 15'h0200,
        PH_NACK_LO = 15'h0400,
        PH_NACK_HI = 15'h0800,
        PH_STOP_LO = 15'h1000,
        PH_STOP_HI = 15'h2000,
        PH_HALT    = 15'h4000
    } phase_t;

    // Which byte of the transfer is in flight, one-hot
    typedef enum logic [2:0] {
        STG_ADDR_W = 3'b001,
        STG_PTR    = 3'b010,
        STG_ADDR_R = 3'b100
    } stage_t;

    // Result of one tick
    typedef struct packed {
        logic       halted_no_ack;
        logic [7:0] read_byte;
        logic       byte_valid;
        logic       sda_out;
        logic       scl_out;
    } tick_result_t;

endpackage

// ===== src/i2c_register_read_master.sv =====
// Top level of the I2C register-read master: stream handshake and result
// register around i2crd_engine. Depends on i2crd_pkg and i2crd_engine.
//
//  group     | dir | beat carries
//  ----------+-----+---------------------------------------------------
//  s_*       | in  | one timer tick with the sampled data line level
//  m_*       | out | line levels, read byte and status for that tick
//  cfg_*     | in  | register write: device address, pointer, half period
//
// One tick is taken per cycle while m_tready does not stall; its result is
// registered in the output register. The sequencer state updates in the same
// cycle as the accept, so a new tick can be taken in the next cycle as the
// previous result drains. A stall on m_tready holds the output register and stops
// ticks from entering. Reset clears the sequencer to bus free and the
// configuration to its defaults.
module i2c_register_read_master #(
    parameter int WAIT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: [0] sda_in, [7:1] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2crd_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: [0] scl_out, [1] sda_out, [2] byte_valid, [10:3] read_byte,
    //          [11] halted_no_ack, [15:12] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2crd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [i2crd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [11:0]                 m_tdata_reg;
    logic                        take;
    i2crd_pkg::tick_result_t     step_res;

    // Accept a tick whenever the output register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    i2crd_engine #(
        .WAIT_BITS (WAIT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (take),
        .sda_in    (s_tdata[0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (step_res)
    );

    // Load or drop the output beat
    assign m_tvalid_next = take ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_tdata_reg <= step_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_tdata_reg};

endmodule

// ===== src/i2crd_engine.sv =====
// Bus sequencer of the I2C register-read master: config registers, phase
// state and the per-tick step logic. Depends on i2crd_pkg.
module i2crd_engine #(
    parameter int WAIT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic                            sda_in,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [i2crd_pkg::CFG_DATA_W-1:0] cfg_data,
    output i2crd_pkg::tick_result_t         result
);

    logic [6:0]            dev_addr_reg;
    logic [7:0]            reg_ptr_reg;
    logic [15:0]           half_ticks_reg;

    i2crd_pkg::phase_t     phase_reg, phase_next;
    i2crd_pkg::stage_t     stage_reg, stage_next;
    logic [3:0]            bit_index_reg, bit_index_next;
    logic [7:0]            shift_byte_reg, shift_byte_next;
    logic [WAIT_BITS-1:0]  wait_count_reg, wait_count_next;
    logic [7:0]            captured_reg, captured_next;
    logic                  halted_reg, halted_next;

    logic [WAIT_BITS-1:0]  period_raw;
    logic [WAIT_BITS-1:0]  period_eff;
    logic [WAIT_BITS:0]    wait_inc;
    logic                  phase_done;
    logic [3:0]            bit_index_inc;
    logic [7:0]            read_shift;
    logic                  scl_o;
    logic                  sda_o;
    logic                  valid_o;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg   <= i2crd_pkg::DEVICE_ADDRESS_RST;
            reg_ptr_reg    <= i2crd_pkg::REGISTER_POINTER_RST;
            half_ticks_reg <= i2crd_pkg::HALF_PERIOD_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2crd_pkg::REG_DEVICE_ADDRESS:    dev_addr_reg   <= cfg_data[6:0];
                i2crd_pkg::REG_REGISTER_POINTER:  reg_ptr_reg    <= cfg_data[7:0];
                i2crd_pkg::REG_HALF_PERIOD_TICKS: half_ticks_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Half-phase timer: period wraps to the timer width, zero acts as one
    assign period_raw    = WAIT_BITS'(half_ticks_reg);
    assign period_eff    = (period_raw == '0) ? WAIT_BITS'(1) : period_raw;
    assign wait_inc      = {1'b0, wait_count_reg} + (WAIT_BITS+1)'(1);
    assign phase_done    = (wait_inc >= {1'b0, period_eff});
    assign bit_index_inc = bit_index_reg + 4'd1;
    assign read_shift    = {shift_byte_reg[6:0], sda_in};

    // Drive line levels of the current half phase
    always_comb
    begin
        scl_o = 1'b1;
        sda_o = 1'b1;
        case (phase_reg)
            i2crd_pkg::PH_IDLE:    begin scl_o = 1'b1; sda_o = 1'b1; end
            i2crd_pkg::PH_START:   begin scl_o = 1'b1; sda_o = 1'b0; end
            i2crd_pkg::PH_WBIT_LO: begin scl_o = 1'b0; sda_o = shift_byte_reg[7]; end
            i2crd_pkg::PH_WBIT_HI: begin scl_o = 1'b1; sda_o = shift_byte_reg[7]; end
            i2crd_pkg::PH_STOP_LO: begin scl_o = 1'b0; sda_o = 1'b0; end
            i2crd_pkg::PH_STOP_HI: begin scl_o = 1'b1; sda_o = 1'b0; end
            i2crd_pkg::PH_HALT,
            i2crd_pkg::PH_ACK_LO,
            i2crd_pkg::PH_RS_LO,
            i2crd_pkg::PH_RBIT_LO,
            i2crd_pkg::PH_NACK_LO: begin scl_o = 1'b0; sda_o = 1'b1; end
            default:               begin scl_o = 1'b1; sda_o = 1'b1; end
        endcase
    end

    // Advance the phase sequencer at the end of each half phase
    always_comb
    begin
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        wait_count_next = wait_count_reg;
        captured_next   = captured_reg;
        halted_next     = halted_reg;
        valid_o         = 1'b0;
        if (phase_reg != i2crd_pkg::PH_HALT)
        begin
            if (!phase_done)
            begin
                wait_count_next = wait_inc[WAIT_BITS-1:0];
            end
            else
            begin
                wait_count_next = '0;
                case (phase_reg)
                    i2crd_pkg::PH_IDLE: phase_next = i2crd_pkg::PH_START;
                    i2crd_pkg::PH_START:
                    begin
                        shift_byte_next = {dev_addr_reg,
                                           (stage_reg == i2crd_pkg::STG_ADDR_R)};
                        bit_index_next  = 4'd0;
                        phase_next      = i2crd_pkg::PH_WBIT_LO;
                    end
                    i2crd_pkg::PH_WBIT_LO: phase_next = i2crd_pkg::PH_WBIT_HI;
                    i2crd_pkg::PH_WBIT_HI:
                    begin
                        shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                        bit_index_next  = bit_index_inc;
                        phase_next      = bit_index_inc[3] ? i2crd_pkg::PH_ACK_LO
                                                           : i2crd_pkg::PH_WBIT_LO;
                    end
                    i2crd_pkg::PH_ACK_LO: phase_next = i2crd_pkg::PH_ACK_HI;
                    i2crd_pkg::PH_ACK_HI:
                    begin
                        if (sda_in)
                        begin
                            halted_next = 1'b1;
                            phase_next  = i2crd_pkg::PH_HALT;
                        end
                        else if (stage_reg == i2crd_pkg::STG_ADDR_W)
                        begin
                            stage_next      = i2crd_pkg::STG_PTR;
                            shift_byte_next = reg_ptr_reg;
                            bit_index_next  = 4'd0;
                            phase_next      = i2crd_pkg::PH_WBIT_LO;
                        end
                        else if (stage_reg == i2crd_pkg::STG_PTR)
                        begin
                            stage_next = i2crd_pkg::STG_ADDR_R;
                            phase_next = i2crd_pkg::PH_RS_LO;
                        end
                        else
                        begin
                            shift_byte_next = 8'd0;
                            bit_index_next  = 4'd0;
                            phase_next      = i2crd_pkg::PH_RBIT_LO;
                        end
                    end
                    i2crd_pkg::PH_RS_LO:   phase_next = i2crd_pkg::PH_RS_HI;
                    i2crd_pkg::PH_RS_HI:   phase_next = i2crd_pkg::PH_START;
                    i2crd_pkg::PH_RBIT_LO: phase_next = i2crd_pkg::PH_RBIT_HI;
                    i2crd_pkg::PH_RBIT_HI:
                    begin
                        shift_byte_next = read_shift;
                        bit_index_next  = bit_index_inc;
                        if (bit_index_inc[3])
                        begin
                            captured_next = read_shift;
                            valid_o       = 1'b1;
                            phase_next    = i2crd_pkg::PH_NACK_LO;
                        end
                        else
                        begin
                            phase_next = i2crd_pkg::PH_RBIT_LO;
                        end
                    end
                    i2crd_pkg::PH_NACK_LO: phase_next = i2crd_pkg::PH_NACK_HI;
                    i2crd_pkg::PH_NACK_HI: phase_next = i2crd_pkg::PH_STOP_LO;
                    i2crd_pkg::PH_STOP_LO: phase_next = i2crd_pkg::PH_STOP_HI;
                    default:
                    begin
                        stage_next = i2crd_pkg::STG_ADDR_W;
                        phase_next = i2crd_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Hold state unless a tick is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2crd_pkg::PH_IDLE;
            stage_reg      <= i2crd_pkg::STG_ADDR_W;
            bit_index_reg  <= 4'd0;
            shift_byte_reg <= 8'd0;
            wait_count_reg <= '0;
            captured_reg   <= 8'd0;
            halted_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            wait_count_reg <= wait_count_next;
            captured_reg   <= captured_next;
            halted_reg     <= halted_next;
        end
    end

    assign result.scl_out       = scl_o;
    assign result.sda_out       = sda_o;
    assign result.byte_valid    = valid_o;
    assign result.read_byte     = captured_next;
    assign result.halted_no_ack = halted_next;

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag dropped");

    // Halt flag and halt phase agree
    a_halt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2crd_pkg::PH_HALT) == halted_reg)
        else $error("halt flag and phase disagree");

    // A byte completes only out of a read-bit high phase
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        valid_o |-> (phase_reg == i2crd_pkg::PH_RBIT_HI) && (bit_index_reg == 4'd7))
        else $error("byte valid outside last read bit");

    // Bit counter never passes eight
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= 4'd8)
        else $error("bit index out of range");

endmodule
